[design/tdf_pkg.sv]
// Shared types and constants for the table-driven state machine engine.
// No dependencies; used by tdf_match and table_driven_fsm_engine.
package tdf_pkg;

	localparam int ID_BITS  = 8;
	localparam int MAX_ROWS = 16;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [7:0]         action_t;

	// Item function codes
	typedef enum logic [1:0] {
		FUNC_DISPATCH = 2'd0,
		FUNC_WRITE    = 2'd1,
		FUNC_RESTART  = 2'd2
	} func_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_ROWS_IN_USE   = 2'd0;
	localparam logic [1:0] CFG_STATE_COUNT   = 2'd1;
	localparam logic [1:0] CFG_INITIAL_STATE = 2'd2;

	typedef struct packed {
		id_t     from_id;
		logic    from_any;
		id_t     trigger;
		logic    trigger_any;
		id_t     next_id;
		action_t action;
	} row_t;

	typedef struct packed {
		logic    fired;
		logic    exit_valid;
		id_t     exit_state;
		action_t action_code;
		logic    entry_valid;
		id_t     state_now;
	} res_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_SCAN
	} seq_state_t;

endpackage

[design/tdf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdf_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/tdf_match.sv]
// Row compare unit: checks one table row against the current state and event.
// Depends on tdf_pkg.
module tdf_match (
	input  tdf_pkg::row_t row,
	input  tdf_pkg::id_t  cur_id,
	input  tdf_pkg::id_t  event_id,
	output logic          hit
);

	logic state_ok;
	logic event_ok;

	assign state_ok = row.from_any || (row.from_id == cur_id);
	assign event_ok = row.trigger_any || (row.trigger == event_id);
	assign hit      = state_ok && event_ok;

endmodule

[design/table_driven_fsm_engine.sv]
// Top level of the table-driven state machine engine: sequencer, config
// registers, row table and result register. Depends on tdf_pkg, tdf_ram, tdf_match.
//
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// item in  | start, busy          | func, event_code, row_* fields
// result   | done (1-cycle strobe)| fired, exit_valid, exit_state, action_code,
//          |                      | entry_valid, state_now
// config   | cfg_we               | cfg_index, cfg_data
//
// A write, restart or unused item gives its result strobe in the cycle after
// acceptance and the next item may be taken at once. A dispatch examines one
// row per cycle through the single compare unit and the one RAM read port:
// it keeps busy high until a row hits or the last row in use is examined
// (1..MAX_ROWS rows), and done rises as busy falls; an empty table acts as a write.
// arst_n clears the state, the sequencer and the config registers; the
// table is not cleared. The receiver cannot stall: done lasts one cycle.
module table_driven_fsm_engine #(
	parameter int MAX_ROWS = tdf_pkg::MAX_ROWS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [1:0]   func,
	input  tdf_pkg::id_t event_code,
	input  logic [3:0]   row_index,
	input  tdf_pkg::id_t row_from,
	input  logic         row_from_any,
	input  tdf_pkg::id_t row_trigger,
	input  logic         row_trigger_any,
	input  tdf_pkg::id_t row_next,
	input  logic [7:0]   row_action,
	output logic         done,
	output logic         fired,
	output logic         exit_valid,
	output tdf_pkg::id_t exit_state,
	output logic [7:0]   action_code,
	output logic         entry_valid,
	output tdf_pkg::id_t state_now,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [8:0]   cfg_data
);

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam logic [8:0] MAX_ROWS_W = 9'(MAX_ROWS);

	tdf_pkg::seq_state_t state_q, state_d;
	logic [CW-1:0]       idx_q;
	tdf_pkg::id_t        event_q;
	tdf_pkg::id_t        current_q;
	logic [4:0]          rows_q;
	logic [8:0]          scount_q;
	tdf_pkg::id_t        init_q;
	tdf_pkg::res_t       res_q, res_d;
	logic                done_q;

	logic [8:0]    len_w;
	logic [CW-1:0] len;
	logic [CW:0]   idx_nx;
	logic          last;
	logic          accept;
	logic          is_dispatch;
	logic          scan_go;
	logic          finish;
	logic          hit;
	logic          row_we;
	logic [8:0]    widx;
	logic [AW-1:0] rd_addr;
	tdf_pkg::row_t wr_row;
	tdf_pkg::row_t rd_row;

	// scan length, clipped to the table depth
	assign len_w = ({4'b0, rows_q} > MAX_ROWS_W) ? MAX_ROWS_W : {4'b0, rows_q};
	assign len   = len_w[CW-1:0];

	assign idx_nx      = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
	assign last        = (idx_nx == {1'b0, len});
	assign busy        = (state_q != tdf_pkg::SEQ_IDLE);
	assign accept      = start && !busy;
	assign is_dispatch = (func == tdf_pkg::FUNC_DISPATCH);
	assign scan_go     = accept && is_dispatch && (len != '0);
	assign widx        = {5'b0, row_index};

	assign wr_row = '{from_id: row_from, from_any: row_from_any, trigger: row_trigger,
		trigger_any: row_trigger_any, next_id: row_next, action: row_action};

	tdf_ram #(
		.WIDTH ($bits(tdf_pkg::row_t)),
		.DEPTH (MAX_ROWS)
	) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (widx[AW-1:0]),
		.wdata (wr_row),
		.raddr (rd_addr),
		.rdata (rd_row)
	);

	tdf_match u_match (
		.row      (rd_row),
		.cur_id   (current_q),
		.event_id (event_q),
		.hit      (hit)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tdf_pkg::SEQ_IDLE: begin
				if (scan_go) begin
					state_d = tdf_pkg::SEQ_SCAN;
				end
			end
			tdf_pkg::SEQ_SCAN: begin
				if (hit || last) begin
					state_d = tdf_pkg::SEQ_IDLE;
				end
			end
			default: state_d = tdf_pkg::SEQ_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		rd_addr = '0;
		row_we  = 1'b0;
		finish  = 1'b0;
		case (state_q)
			tdf_pkg::SEQ_IDLE: begin
				row_we = accept && (func == tdf_pkg::FUNC_WRITE) && (widx < MAX_ROWS_W);
				finish = accept && !scan_go;
			end
			tdf_pkg::SEQ_SCAN: begin
				// prefetch the following row while this one is compared
				if (!last) begin
					rd_addr = idx_nx[AW-1:0];
				end
				finish = hit || last;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	// Result content
	always_comb begin
		res_d           = '0;
		res_d.state_now = current_q;
		if (state_q == tdf_pkg::SEQ_SCAN) begin
			if (hit) begin
				res_d.fired       = 1'b1;
				res_d.exit_valid  = ({1'b0, current_q} < scount_q);
				res_d.exit_state  = current_q;
				res_d.action_code = rd_row.action;
				res_d.entry_valid = ({1'b0, rd_row.next_id} < scount_q);
				res_d.state_now   = rd_row.next_id;
			end
		end else if (func == tdf_pkg::FUNC_RESTART) begin
			res_d.entry_valid = ({1'b0, init_q} < scount_q);
			res_d.state_now   = init_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tdf_pkg::SEQ_IDLE;
			idx_q     <= '0;
			current_q <= '0;
			rows_q    <= '0;
			scount_q  <= '0;
			init_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= finish;
			if (scan_go) begin
				idx_q <= '0;
			end else if (state_q == tdf_pkg::SEQ_SCAN) begin
				idx_q <= idx_nx[CW-1:0];
			end
			if (finish) begin
				current_q <= res_d.state_now;
			end
			if (cfg_we) begin
				case (cfg_index)
					tdf_pkg::CFG_ROWS_IN_USE:   rows_q   <= cfg_data[4:0];
					tdf_pkg::CFG_STATE_COUNT:   scount_q <= cfg_data;
					tdf_pkg::CFG_INITIAL_STATE: init_q   <= cfg_data[7:0];
					default:                    rows_q   <= rows_q;
				endcase
			end
		end
	end

	// Hold the event and the result payload
	always_ff @(posedge clk) begin
		if (scan_go) begin
			event_q <= event_code;
		end
		if (finish) begin
			res_q <= res_d;
		end
	end

	assign done        = done_q;
	assign fired       = res_q.fired;
	assign exit_valid  = res_q.exit_valid;
	assign exit_state  = res_q.exit_state;
	assign action_code = res_q.action_code;
	assign entry_valid = res_q.entry_valid;
	assign state_now   = res_q.state_now;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the scan is still running");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !fired) |-> (!exit_valid && exit_state == '0 && action_code == '0))
		else $error("no-fire result carries exit or action data");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tdf_pkg::SEQ_SCAN) |-> (idx_q < len))
		else $error("scan index ran past the table length");

	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		scan_go |=> (busy && idx_q == '0))
		else $error("dispatch did not start a scan at row zero");

endmodule
